### sv/srd_pkg.sv
// Shared types and constants for the sprite row run-length decoder.
`default_nettype none

package srd_pkg;

  localparam int unsigned MaxWidth   = 4095;
  localparam logic [11:0] WidthReset = 12'd4095;

  typedef enum logic [2:0] {
    KindTrans   = 3'd0,
    KindColor   = 3'd1,
    KindPlayer  = 3'd2,
    KindShadow  = 3'd3,
    KindShield  = 3'd4,
    KindOutline = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    OpNop   = 3'd0,
    OpRun   = 3'd1,
    OpEol   = 3'd2,
    OpFail  = 3'd3,
    OpBlank = 3'd4
  } op_e;

  // one request for the back end; new_row restarts column and halt state
  typedef struct packed {
    op_e         op;
    logic        new_row;
    kind_e       kind;
    logic [7:0]  color;
    logic [11:0] len;
  } req_t;

  // everything one item asks for: row-start part, then command part
  typedef struct packed {
    logic a_vld;
    req_t a;
    logic b_vld;
    req_t b;
  } entry_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  color;
    logic [11:0] len;
    logic        row_done;
    logic        error;
  } res_t;

endpackage

`default_nettype wire

### sv/srd_item_if.sv
// Input item channel: one command byte with its row flags.
`default_nettype none

interface srd_item_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cmd_byte;
  logic        row_start;
  logic [11:0] left_edge;
  logic        blank_row;

  modport source (output valid, cmd_byte, row_start, left_edge, blank_row, input ready);
  modport sink (input valid, cmd_byte, row_start, left_edge, blank_row, output ready);
endinterface

`default_nettype wire

### sv/srd_run_if.sv
// Output item channel: one decoded pixel run.
`default_nettype none

interface srd_run_if;
  logic        valid;
  logic        ready;
  logic [2:0]  pixel_kind;
  logic [7:0]  color_index;
  logic [11:0] run_length;
  logic        row_done;
  logic        error;

  modport source (output valid, pixel_kind, color_index, run_length, row_done, error,
                  input ready);
  modport sink (input valid, pixel_kind, color_index, run_length, row_done, error,
                output ready);
endinterface

`default_nettype wire

### sv/srd_front.sv
// Front end: byte parser that turns items into run, end-of-line, fail and blank-row requests.
`default_nettype none

module srd_front import srd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  srd_item_if.sink   item_i,
  input  logic       full_i,
  output logic       push_o,
  output entry_t     entry_o
);

  localparam logic [2:0] PhCmd       = 3'd0;
  localparam logic [2:0] PhCntRun    = 3'd1;
  localparam logic [2:0] PhCntList   = 3'd2;
  localparam logic [2:0] PhCntFill   = 3'd3;
  localparam logic [2:0] PhBigRun    = 3'd4;
  localparam logic [2:0] PhBigList   = 3'd5;
  localparam logic [2:0] PhList      = 3'd6;
  localparam logic [2:0] PhFillColor = 3'd7;

  localparam logic [1:0] CmdList       = 2'b00;
  localparam logic [1:0] CmdSkip       = 2'b01;
  localparam logic [3:0] CmdBigList    = 4'h2;
  localparam logic [3:0] CmdBigSkip    = 4'h3;
  localparam logic [3:0] CmdPlayerList = 4'h6;
  localparam logic [3:0] CmdFill       = 4'h7;
  localparam logic [3:0] CmdPlayerFill = 4'hA;
  localparam logic [3:0] CmdShadow     = 4'hB;
  localparam logic [7:0] CmdShieldRun  = 8'h7E;
  localparam logic [7:0] CmdOutlineRun = 8'h5E;
  localparam logic [7:0] CmdShieldOne  = 8'h6E;
  localparam logic [7:0] CmdOutlineOne = 8'h4E;
  localparam logic [7:0] CmdEol        = 8'h0F;

  logic [2:0]  phase_q, phase_d;
  kind_e       pkind_q, pkind_d;
  logic [11:0] pcnt_q, pcnt_d;
  logic [3:0]  hnib_q, hnib_d;

  logic        take;
  logic [7:0]  b;
  logic [3:0]  nib;
  logic [2:0]  ph;
  kind_e       pk;
  logic [11:0] pc;
  logic [3:0]  hn;
  logic [11:0] big;
  logic [11:0] pc_dec;
  req_t        cmd_req;

  function automatic req_t mk_run(kind_e k, logic [7:0] c, logic [11:0] l);
    req_t r;
    r         = '0;
    r.op      = OpRun;
    r.kind    = k;
    r.color   = (k == KindColor || k == KindPlayer) ? c : 8'd0;
    r.len     = l;
    return r;
  endfunction

  assign item_i.ready = !full_i;
  assign take         = item_i.valid && item_i.ready;

  always_comb begin
    b       = item_i.cmd_byte;
    nib     = b[7:4];
    entry_o = '0;
    ph      = phase_q;
    pk      = pkind_q;
    pc      = pcnt_q;
    hn      = hnib_q;
    if (item_i.row_start || item_i.blank_row) begin
      ph                 = PhCmd;
      pk                 = KindTrans;
      pc                 = '0;
      hn                 = '0;
      entry_o.a_vld      = 1'b1;
      entry_o.a.new_row  = 1'b1;
      entry_o.a.kind     = KindTrans;
      if (item_i.blank_row) begin
        entry_o.a.op = OpBlank;
      end else begin
        entry_o.a.op  = OpRun;
        entry_o.a.len = item_i.left_edge;
      end
    end
    phase_d = ph;
    pkind_d = pk;
    pcnt_d  = pc;
    hnib_d  = hn;
    big     = {hn, b};
    pc_dec  = pc - 12'd1;
    cmd_req = '0;
    if (!item_i.blank_row) begin
      case (ph)
        PhCmd: begin
          if (b[1:0] == CmdList) begin
            pkind_d = KindColor;
            pcnt_d  = {6'd0, b[7:2]};
            phase_d = (b[7:2] != 6'd0) ? PhList : PhCmd;
          end else if (b[1:0] == CmdSkip) begin
            if (b[7:2] == 6'd0) begin
              pkind_d = KindTrans;
              phase_d = PhCntRun;
            end else begin
              cmd_req = mk_run(KindTrans, 8'd0, {6'd0, b[7:2]});
            end
          end else begin
            case (b[3:0])
              CmdBigList: begin
                pkind_d = KindColor;
                hnib_d  = nib;
                phase_d = PhBigList;
              end
              CmdBigSkip: begin
                pkind_d = KindTrans;
                hnib_d  = nib;
                phase_d = PhBigRun;
              end
              CmdPlayerList: begin
                pkind_d = KindPlayer;
                if (nib == 4'd0) begin
                  phase_d = PhCntList;
                end else begin
                  pcnt_d  = {8'd0, nib};
                  phase_d = PhList;
                end
              end
              CmdFill, CmdPlayerFill: begin
                pkind_d = (b[3:0] == CmdFill) ? KindColor : KindPlayer;
                if (nib == 4'd0) begin
                  phase_d = PhCntFill;
                end else begin
                  pcnt_d  = {8'd0, nib};
                  phase_d = PhFillColor;
                end
              end
              CmdShadow: begin
                if (nib == 4'd0) begin
                  pkind_d = KindShadow;
                  phase_d = PhCntRun;
                end else begin
                  cmd_req = mk_run(KindShadow, 8'd0, {8'd0, nib});
                end
              end
              default: begin
                case (b)
                  CmdShieldRun: begin
                    pkind_d = KindShield;
                    phase_d = PhCntRun;
                  end
                  CmdOutlineRun: begin
                    pkind_d = KindOutline;
                    phase_d = PhCntRun;
                  end
                  CmdShieldOne:  cmd_req = mk_run(KindShield, 8'd0, 12'd1);
                  CmdOutlineOne: cmd_req = mk_run(KindOutline, 8'd0, 12'd1);
                  CmdEol:        cmd_req.op = OpEol;
                  default:       cmd_req.op = OpFail;
                endcase
              end
            endcase
          end
        end
        PhCntRun: begin
          phase_d = PhCmd;
          cmd_req = mk_run(pk, 8'd0, {4'd0, b});
        end
        PhCntList: begin
          pcnt_d  = {4'd0, b};
          phase_d = (b != 8'd0) ? PhList : PhCmd;
        end
        PhCntFill: begin
          pcnt_d  = {4'd0, b};
          phase_d = PhFillColor;
        end
        PhBigRun: begin
          phase_d = PhCmd;
          cmd_req = mk_run(pk, 8'd0, big);
        end
        PhBigList: begin
          pcnt_d  = big;
          phase_d = (big != 12'd0) ? PhList : PhCmd;
        end
        PhList: begin
          cmd_req = mk_run(pk, b, 12'd1);
          pcnt_d  = pc_dec;
          if (pc_dec == 12'd0) begin
            phase_d = PhCmd;
          end
        end
        default: begin
          phase_d = PhCmd;
          cmd_req = mk_run(pk, b, pc);
        end
      endcase
    end
    entry_o.b     = cmd_req;
    entry_o.b_vld = (cmd_req.op == OpRun) ? (cmd_req.len != 12'd0) : (cmd_req.op != OpNop);
    push_o        = take && (entry_o.a_vld || entry_o.b_vld);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhCmd;
      pkind_q <= KindTrans;
      pcnt_q  <= '0;
      hnib_q  <= '0;
    end else if (take) begin
      phase_q <= phase_d;
      pkind_q <= pkind_d;
      pcnt_q  <= pcnt_d;
      hnib_q  <= hnib_d;
    end
  end

endmodule

`default_nettype wire

### sv/srd_queue.sv
// Request queue between parser and run emitter.
`default_nettype none

module srd_queue import srd_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   vld_o,
  output entry_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o = (count_q == CntW'(Depth));
  assign vld_o  = (count_q != '0);
  assign head_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ((wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop_i ? ((rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> vld_o) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

### sv/srd_back.sv
// Back end: column tracking, width checks and the output register.
`default_nettype none

module srd_back import srd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        q_vld_i,
  input  entry_t      head_i,
  output logic        pop_o,
  srd_run_if.source   run_o
);

  logic [11:0] width_q;
  logic [11:0] column_q, column_d;
  logic        halted_q, halted_d;
  logic        half_q, half_d;
  logic        out_vld_q;
  res_t        res_q, res_d;

  logic        sel_b;
  req_t        cur;
  logic        adv;
  logic        emit;
  logic [11:0] wiu;
  logic [11:0] col_e;
  logic        hlt_e;
  logic [12:0] sum;

  assign wiu   = ({20'd0, width_q} > MaxWidth) ? 12'(MaxWidth) : width_q;
  assign sel_b = half_q || !head_i.a_vld;
  assign cur   = sel_b ? head_i.b : head_i.a;
  assign adv   = q_vld_i && (!out_vld_q || run_o.ready);
  assign pop_o = adv && (sel_b || !head_i.b_vld);

  always_comb begin
    half_d   = adv ? (!sel_b && head_i.b_vld) : half_q;
    col_e    = cur.new_row ? 12'd0 : column_q;
    hlt_e    = cur.new_row ? 1'b0 : halted_q;
    sum      = {1'b0, col_e} + {1'b0, cur.len};
    column_d = col_e;
    halted_d = hlt_e;
    emit     = 1'b0;
    res_d    = '0;
    if (!hlt_e) begin
      case (cur.op)
        OpRun: begin
          if (cur.len != 12'd0) begin
            emit = 1'b1;
            if (sum > {1'b0, wiu}) begin
              res_d.row_done = 1'b1;
              res_d.error    = 1'b1;
              halted_d       = 1'b1;
            end else begin
              column_d    = sum[11:0];
              res_d.kind  = cur.kind;
              res_d.color = cur.color;
              res_d.len   = cur.len;
            end
          end
        end
        OpEol: begin
          emit           = 1'b1;
          res_d.len      = (wiu > col_e) ? (wiu - col_e) : 12'd0;
          res_d.row_done = 1'b1;
          halted_d       = 1'b1;
        end
        OpFail: begin
          emit           = 1'b1;
          res_d.row_done = 1'b1;
          res_d.error    = 1'b1;
          halted_d       = 1'b1;
        end
        OpBlank: begin
          emit           = 1'b1;
          res_d.len      = wiu;
          res_d.row_done = 1'b1;
          halted_d       = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WidthReset;
      column_q  <= '0;
      halted_q  <= 1'b0;
      half_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      half_q <= half_d;
      if (adv) begin
        column_q  <= column_d;
        halted_q  <= halted_d;
        out_vld_q <= emit;
      end else if (run_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      res_q <= res_d;
    end
  end

  assign run_o.valid       = out_vld_q;
  assign run_o.pixel_kind  = res_q.kind;
  assign run_o.color_index = res_q.color;
  assign run_o.run_length  = res_q.len;
  assign run_o.row_done    = res_q.row_done;
  assign run_o.error       = res_q.error;

`ifndef ASSERT_OFF
  a_err_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.error |-> res_q.row_done && (res_q.len == 12'd0))
    else $error("error item must close the row with zero length");
  a_done_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && emit && res_d.row_done |=> halted_q)
    else $error("row closed but emitter not halted");
  a_half_has_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |-> q_vld_i && head_i.b_vld)
    else $error("second half pending without a command request");
`endif

endmodule

`default_nettype wire

### sv/sprite_row_rle_decoder.sv
// Top level of the sprite row run-length decoder.
//
//  channel   dir  handshake          payload
//  item_i    in   valid/ready        cmd_byte, row_start, left_edge, blank_row
//  run_o     out  valid/ready        pixel_kind, color_index, run_length, row_done, error
//  cfg       in   cfg_we_i           cfg_wdata_i (frame width)
//
// One item is taken per cycle while the request queue has room.
// An item yields up to two requests; the emitter takes one per cycle unless run_o
// stalls, and a row-start item with a command request stays at the queue head for both.
// A run becomes valid only after its item has passed the request queue and the output register.
// item_i.ready drops only when all QueueDepth queue entries are in use.
// Reset clears parse state, column, queue and output valid; width resets to 4095.
`default_nettype none

module sprite_row_rle_decoder import srd_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  srd_item_if.sink    item_i,
  srd_run_if.source   run_o
);

  logic   push;
  logic   full;
  logic   pop;
  logic   q_vld;
  entry_t entry;
  entry_t head;

  srd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  srd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .vld_o   (q_vld),
    .head_o  (head)
  );

  srd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_vld_i     (q_vld),
    .head_i      (head),
    .pop_o       (pop),
    .run_o       (run_o)
  );

endmodule

`default_nettype wire

### tb/srd_tb_pkg.sv
// Command byte codes and the stimulus item type for the sprite row decoder testbench.
`timescale 1ns / 100ps
`default_nettype none

package srd_tb_pkg;

  // low two bits of a command
  localparam logic [1:0] LoList = 2'b00;
  localparam logic [1:0] LoSkip = 2'b01;

  // low nibble of a command
  localparam logic [3:0] NibBigList    = 4'h2;
  localparam logic [3:0] NibBigSkip    = 4'h3;
  localparam logic [3:0] NibPlayerList = 4'h6;
  localparam logic [3:0] NibColorFill  = 4'h7;
  localparam logic [3:0] NibPlayerFill = 4'hA;
  localparam logic [3:0] NibShadow     = 4'hB;

  // whole-byte commands
  localparam logic [7:0] CmdShieldRun  = 8'h7E;
  localparam logic [7:0] CmdOutlineRun = 8'h5E;
  localparam logic [7:0] CmdShieldPx   = 8'h6E;
  localparam logic [7:0] CmdOutlinePx  = 8'h4E;
  localparam logic [7:0] CmdEol        = 8'h0F;

  typedef struct packed {
    logic [7:0]  cmd;
    logic        row_start;
    logic [11:0] left_edge;
    logic        blank_row;
  } byte_item_t;

endpackage

`default_nettype wire

### tb/sprite_row_rle_checker.sv
// Watches the decoder channels, predicts the pixel runs and compares them.
`timescale 1ns / 100ps
`default_nettype none

module sprite_row_rle_checker import srd_pkg::*, srd_tb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  srd_item_if         item_mon,
  srd_run_if          run_mon,
  output int unsigned bad_runs_o,
  output int unsigned runs_waiting_o
);

  typedef enum logic [2:0] {
    PhCmd, PhCntRun, PhCntList, PhCntFill, PhBigRun, PhBigList, PhList, PhFillColor
  } phase_e;

  logic [11:0] width_q;
  phase_e      phase_q;
  kind_e       pkind_q;
  logic [11:0] pcount_q;
  logic [3:0]  hinib_q;
  logic [11:0] col_q;
  logic        halted_q;
  res_t        runs_due[$];
  int unsigned bad_cnt;

  function automatic logic [11:0] width_now();
    return (32'(width_q) > MaxWidth) ? 12'(MaxWidth) : width_q;
  endfunction

  function automatic void push_run(kind_e k, logic [7:0] c, logic [11:0] len,
                                   logic done, logic err);
    res_t r;
    r.kind     = k;
    r.color    = c;
    r.len      = len;
    r.row_done = done;
    r.error    = err;
    runs_due.push_back(r);
  endfunction

  function automatic void row_fail();
    push_run(KindTrans, 8'd0, 12'd0, 1'b1, 1'b1);
    halted_q = 1'b1;
    phase_q  = PhCmd;
  endfunction

  // returns 0 when the run overflows the row
  function automatic bit place_run(kind_e k, logic [7:0] c, logic [11:0] len);
    if (len == 12'd0) return 1'b1;
    if ({1'b0, col_q} + {1'b0, len} > {1'b0, width_now()}) begin
      row_fail();
      return 1'b0;
    end
    col_q = col_q + len;
    push_run(k, (k == KindColor || k == KindPlayer) ? c : 8'd0, len, 1'b0, 1'b0);
    return 1'b1;
  endfunction

  function automatic void set_counted(kind_e k, logic [3:0] nib, phase_e via_cnt,
                                      phase_e direct);
    pkind_q = k;
    if (nib == 4'd0) begin
      phase_q = via_cnt;
    end else begin
      pcount_q = {8'd0, nib};
      phase_q  = direct;
    end
  endfunction

  function automatic void decode_cmd(logic [7:0] b);
    logic [11:0] w;
    if (b[1:0] == LoList) begin
      pkind_q  = KindColor;
      pcount_q = {6'd0, b[7:2]};
      phase_q  = (pcount_q != 12'd0) ? PhList : PhCmd;
    end else if (b[1:0] == LoSkip) begin
      if (b[7:2] == 6'd0) begin
        pkind_q = KindTrans;
        phase_q = PhCntRun;
      end else begin
        void'(place_run(KindTrans, 8'd0, {6'd0, b[7:2]}));
      end
    end else if (b[3:0] == NibBigList) begin
      pkind_q = KindColor;
      hinib_q = b[7:4];
      phase_q = PhBigList;
    end else if (b[3:0] == NibBigSkip) begin
      pkind_q = KindTrans;
      hinib_q = b[7:4];
      phase_q = PhBigRun;
    end else if (b[3:0] == NibPlayerList) begin
      set_counted(KindPlayer, b[7:4], PhCntList, PhList);
    end else if (b[3:0] == NibColorFill) begin
      set_counted(KindColor, b[7:4], PhCntFill, PhFillColor);
    end else if (b[3:0] == NibPlayerFill) begin
      set_counted(KindPlayer, b[7:4], PhCntFill, PhFillColor);
    end else if (b[3:0] == NibShadow) begin
      if (b[7:4] == 4'd0) begin
        pkind_q = KindShadow;
        phase_q = PhCntRun;
      end else begin
        void'(place_run(KindShadow, 8'd0, {8'd0, b[7:4]}));
      end
    end else if (b == CmdShieldRun) begin
      pkind_q = KindShield;
      phase_q = PhCntRun;
    end else if (b == CmdOutlineRun) begin
      pkind_q = KindOutline;
      phase_q = PhCntRun;
    end else if (b == CmdShieldPx) begin
      void'(place_run(KindShield, 8'd0, 12'd1));
    end else if (b == CmdOutlinePx) begin
      void'(place_run(KindOutline, 8'd0, 12'd1));
    end else if (b == CmdEol) begin
      w = width_now();
      push_run(KindTrans, 8'd0, (w > col_q) ? w - col_q : 12'd0, 1'b1, 1'b0);
      halted_q = 1'b1;
    end else begin
      row_fail();
    end
  endfunction

  function automatic void decode_item(logic [7:0] b, logic rs, logic [11:0] le, logic bl);
    logic [11:0] cnt;
    if (rs || bl) begin
      col_q    = 12'd0;
      halted_q = 1'b0;
      phase_q  = PhCmd;
      pkind_q  = KindTrans;
      pcount_q = 12'd0;
      hinib_q  = 4'd0;
      if (bl) begin
        push_run(KindTrans, 8'd0, width_now(), 1'b1, 1'b0);
        halted_q = 1'b1;
        return;
      end
      if (!place_run(KindTrans, 8'd0, le)) return;
    end
    if (halted_q) return;
    case (phase_q)
      PhCmd: decode_cmd(b);
      PhCntRun: begin
        phase_q = PhCmd;
        void'(place_run(pkind_q, 8'd0, {4'd0, b}));
      end
      PhCntList: begin
        pcount_q = {4'd0, b};
        phase_q  = (b != 8'd0) ? PhList : PhCmd;
      end
      PhCntFill: begin
        pcount_q = {4'd0, b};
        phase_q  = PhFillColor;
      end
      PhBigRun: begin
        cnt     = {hinib_q, b};
        phase_q = PhCmd;
        void'(place_run(pkind_q, 8'd0, cnt));
      end
      PhBigList: begin
        cnt      = {hinib_q, b};
        pcount_q = cnt;
        phase_q  = (cnt != 12'd0) ? PhList : PhCmd;
      end
      PhList: begin
        if (place_run(pkind_q, b, 12'd1)) begin
          pcount_q = pcount_q - 12'd1;
          if (pcount_q == 12'd0) phase_q = PhCmd;
        end
      end
      default: begin
        phase_q = PhCmd;
        void'(place_run(pkind_q, b, pcount_q));
      end
    endcase
  endfunction

  function automatic void flag(string what, res_t want, res_t got);
    bad_cnt++;
    if (bad_cnt <= 10) begin
      $write("%0t %s: want kind %0d color %0d len %0d done %0b err %0b,",
             $time, what, want.kind, want.color, want.len, want.row_done, want.error);
      $display(" got kind %0d color %0d len %0d done %0b err %0b",
               got.kind, got.color, got.len, got.row_done, got.error);
    end
  endfunction

  function automatic void check_run();
    res_t got;
    res_t want;
    got.kind     = kind_e'(run_mon.pixel_kind);
    got.color    = run_mon.color_index;
    got.len      = run_mon.run_length;
    got.row_done = run_mon.row_done;
    got.error    = run_mon.error;
    if (runs_due.size() == 0) begin
      want = '0;
      flag("run with none due", want, got);
    end else begin
      want = runs_due.pop_front();
      if (got !== want) flag("run mismatch", want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  = WidthReset;
      phase_q  = PhCmd;
      pkind_q  = KindTrans;
      pcount_q = 12'd0;
      hinib_q  = 4'd0;
      col_q    = 12'd0;
      halted_q = 1'b0;
      bad_cnt  = 0;
      runs_due.delete();
      bad_runs_o     <= 0;
      runs_waiting_o <= 0;
    end else begin
      if (cfg_we_i) width_q = cfg_wdata_i;
      if (run_mon.valid && run_mon.ready) check_run();
      if (item_mon.valid && item_mon.ready)
        decode_item(item_mon.cmd_byte, item_mon.row_start, item_mon.left_edge,
                    item_mon.blank_row);
      bad_runs_o     <= bad_cnt;
      runs_waiting_o <= runs_due.size();
    end
  end

endmodule

`default_nettype wire

### tb/sprite_row_rle_decoder_tb.sv
// Testbench top for the sprite row decoder: clock, reset, byte stream and run sink.
`timescale 1ns / 100ps
`default_nettype none

module sprite_row_rle_decoder_tb import srd_pkg::*, srd_tb_pkg::*; ();

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [11:0] cfg_wdata;
  int unsigned bad_runs;
  int unsigned runs_waiting;

  srd_item_if item_ch ();
  srd_run_if  run_ch ();

  sprite_row_rle_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .item_i     (item_ch),
    .run_o      (run_ch)
  );

  sprite_row_rle_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .item_mon      (item_ch),
    .run_mon       (run_ch),
    .bad_runs_o    (bad_runs),
    .runs_waiting_o(runs_waiting)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  byte_item_t  items[$];
  logic        rs_next = 1'b0;
  logic [11:0] le_next = 12'd0;
  int unsigned cur_width = 4095;
  bit          no_gaps = 1'b0;
  int unsigned hold_ask = 0;
  int unsigned hold_done = 0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic void put(logic [7:0] b);
    byte_item_t it;
    it.cmd       = b;
    it.row_start = rs_next;
    it.left_edge = rs_next ? le_next : 12'($urandom);
    it.blank_row = 1'b0;
    items.push_back(it);
    rs_next = 1'b0;
  endfunction

  function automatic void put_blank();
    byte_item_t it;
    it.cmd       = 8'($urandom);
    it.row_start = 1'($urandom);
    it.left_edge = 12'($urandom);
    it.blank_row = 1'b1;
    items.push_back(it);
  endfunction

  function automatic void begin_row(logic [11:0] le);
    rs_next = 1'b1;
    le_next = le;
  endfunction

  function automatic void put_data(int unsigned n);
    repeat (n) put(8'($urandom));
  endfunction

  function automatic logic [7:0] pick_count();
    int unsigned r;
    r = $urandom_range(9, 0);
    if (r < 7) return 8'($urandom_range(6, 0));
    if (r < 9) return 8'($urandom_range(40, 7));
    return 8'($urandom_range(255, 41));
  endfunction

  function automatic logic [7:0] pick_unknown();
    logic [7:0] b;
    do begin
      b = {4'($urandom), $urandom_range(1, 0) ? 4'hE : 4'hF};
    end while (b == CmdShieldRun || b == CmdOutlineRun || b == CmdShieldPx ||
               b == CmdOutlinePx || b == CmdEol);
    return b;
  endfunction

  function automatic void put_cmd();
    int unsigned n;
    logic [3:0]  hi;
    case ($urandom_range(10, 0))
      0: begin
        n = ($urandom_range(49, 0) == 0) ? 63 : $urandom_range(8, 0);
        put({n[5:0], LoList});
        put_data(n);
      end
      1: begin
        if ($urandom_range(1, 0)) begin
          put({6'($urandom_range(63, 1)), LoSkip});
        end else begin
          put({6'd0, LoSkip});
          put(pick_count());
        end
      end
      2: begin
        if ($urandom_range(9, 0) != 0) begin
          n = $urandom_range(8, 0);
          put({4'd0, NibBigList});
          put(n[7:0]);
          put_data(n);
        end else begin
          // oversized list, cut short by the next row
          put({4'($urandom_range(15, 1)), NibBigList});
          put(8'($urandom));
          put_data($urandom_range(4, 0));
        end
      end
      3: begin
        hi = ($urandom_range(3, 0) == 0) ? 4'($urandom) : 4'd0;
        put({hi, NibBigSkip});
        put((hi == 4'd0) ? pick_count() : 8'($urandom));
      end
      4: begin
        if ($urandom_range(1, 0)) begin
          n = $urandom_range(8, 0);
          put({4'd0, NibPlayerList});
          put(n[7:0]);
        end else begin
          n = $urandom_range(15, 1);
          put({n[3:0], NibPlayerList});
        end
        put_data(n);
      end
      5, 6: begin
        if ($urandom_range(1, 0)) begin
          put({4'd0, ($urandom_range(1, 0) ? NibColorFill : NibPlayerFill)});
          put(pick_count());
        end else begin
          put({4'($urandom_range(15, 1)), ($urandom_range(1, 0) ? NibColorFill : NibPlayerFill)});
        end
        put(8'($urandom));
      end
      7: begin
        if ($urandom_range(1, 0)) begin
          put({4'd0, NibShadow});
          put(pick_count());
        end else begin
          put({4'($urandom_range(15, 1)), NibShadow});
        end
      end
      8: begin
        put($urandom_range(1, 0) ? CmdShieldRun : CmdOutlineRun);
        put(pick_count());
      end
      9: put($urandom_range(1, 0) ? CmdShieldPx : CmdOutlinePx);
      default: put(($urandom_range(3, 0) == 0) ? pick_unknown() : CmdShieldPx);
    endcase
  endfunction

  function automatic void gen_row();
    int unsigned r;
    logic [11:0] le;
    r = $urandom_range(99, 0);
    if (r < 40) le = 12'd0;
    else if (r < 90) le = 12'($urandom_range(cur_width / 4 + 1, 1));
    else le = 12'($urandom);
    begin_row(le);
    repeat ($urandom_range(6, 0)) put_cmd();
    r = $urandom_range(99, 0);
    if (r < 85) put(CmdEol);
    else if (r < 92) put(pick_unknown());
    if ($urandom_range(9, 0) == 0) put_data($urandom_range(3, 1));
  endfunction

  function automatic void fill_random(int unsigned n);
    while (items.size() < n) begin
      if ($urandom_range(99, 0) < 8) put_blank();
      else gen_row();
    end
  endfunction

  function automatic void fill_directed();
    put_blank();
    begin_row(12'd0);
    put({6'd2, LoList});
    put(8'h00);
    put(8'hFF);
    put({6'd1, LoSkip});
    put({6'd0, LoSkip});
    put(8'd0);
    put({4'd0, NibBigList});
    put(8'd1);
    put(8'hAB);
    put({4'd0, NibBigSkip});
    put(8'd0);
    put({4'd1, NibPlayerList});
    put(8'h7F);
    put({4'd2, NibColorFill});
    put(8'h80);
    put({4'd0, NibPlayerFill});
    put(8'd0);
    put(8'h55);
    put({4'd1, NibShadow});
    put(CmdShieldRun);
    put(8'd3);
    put(CmdOutlineRun);
    put(8'd2);
    put(CmdShieldPx);
    put(CmdOutlinePx);
    put(CmdEol);
    begin_row(12'd5);
    put(pick_unknown());
    put({6'd1, LoSkip});
    begin_row(12'd4095);
    put(CmdShieldPx);
  endfunction

  task automatic send_all();
    byte_item_t  it;
    int unsigned gap;
    while (items.size() != 0) begin
      it  = items.pop_front();
      gap = pick_gap();
      if (gap != 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      item_ch.valid     <= 1'b1;
      item_ch.cmd_byte  <= it.cmd;
      item_ch.row_start <= it.row_start;
      item_ch.left_edge <= it.left_edge;
      item_ch.blank_row <= it.blank_row;
      do @(posedge clk_i); while (!item_ch.ready);
    end
    item_ch.valid <= 1'b0;
  endtask

  // every due run back, then room for items that give none
  task automatic drain();
    do @(posedge clk_i); while (runs_waiting != 0);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_width(logic [11:0] w);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    cur_width = w;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    run_ch.ready = 1'b0;
    forever begin
      int unsigned stall;
      run_ch.ready <= 1'b1;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
      if (hold_ask != hold_done) begin
        hold_done = hold_ask;
        stall = 300;
      end else begin
        stall = pick_gap();
      end
      if (stall != 0) begin
        run_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = 12'd0;
    item_ch.valid     = 1'b0;
    item_ch.cmd_byte  = 8'd0;
    item_ch.row_start = 1'b0;
    item_ch.left_edge = 12'd0;
    item_ch.blank_row = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fill_directed();
    send_all();
    drain();

    set_width(12'd1);
    fill_random(60);
    send_all();
    drain();

    set_width(12'd4095);
    fill_random(150);
    send_all();
    drain();

    // output held off while bytes keep coming
    set_width(12'd48);
    no_gaps = 1'b1;
    hold_ask++;
    fill_random(80);
    send_all();
    no_gaps = 1'b0;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      set_width(12'($urandom_range(300, 2)));
      no_gaps = (ph == 1);
      fill_random(130);
      send_all();
      no_gaps = 1'b0;
      drain();
    end

    set_width(12'($urandom_range(4095, 1000)));
    fill_random(60);
    send_all();
    drain();

    if (bad_runs == 0) $display("sprite_row_rle_decoder_tb: clean");
    else $display("sprite_row_rle_decoder_tb: errors");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("sprite_row_rle_decoder_tb: errors");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
sv/srd_pkg.sv
sv/srd_item_if.sv
sv/srd_run_if.sv
sv/srd_front.sv
sv/srd_queue.sv
sv/srd_back.sv
sv/sprite_row_rle_decoder.sv
tb/srd_tb_pkg.sv
tb/sprite_row_rle_checker.sv
tb/sprite_row_rle_decoder_tb.sv
